FILE: hw/rtl/lzbd_pkg.sv
package lzbd_pkg;

    // history window
    localparam int WINDOW_DEPTH = 2048;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

    // stream fields
    localparam int BYTE_W  = 8;
    localparam int DIST_W  = 11;
    localparam int LEN_W   = 32;
    localparam int COPY_W  = 6;
    localparam int RUN_W   = 8;
    localparam int HIGH_W  = 7;

    // token layout
    localparam int TOKEN_MATCH_BIT = 7;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_OUTPUT_LENGTH = '0;

    typedef enum logic [3:0] {
        PH_TOKEN     = 4'b0001,
        PH_LITERAL   = 4'b0010,
        PH_MATCH_LOW = 4'b0100,
        PH_COPY      = 4'b1000
    } t_phase;

    typedef struct packed {
        logic              en;
        logic [WIN_AW-1:0] addr;
        logic              zero;
    } t_win_rd;

    typedef struct packed {
        logic              en;
        logic [WIN_AW-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_win_wr;

endpackage

FILE: hw/rtl/lzbd_window.sv
module lzbd_window (
    input  logic                          i_clk,
    input  lzbd_pkg::t_win_wr             i_wr,
    input  lzbd_pkg::t_win_rd             i_rd,
    output logic [lzbd_pkg::BYTE_W-1:0]   o_rd_data
);
    import lzbd_pkg::*;

    logic [BYTE_W-1:0] r_mem [WINDOW_DEPTH];
    logic [BYTE_W-1:0] r_q;
    logic [BYTE_W-1:0] r_fwd_data;
    logic              r_fwd_hit;
    logic              r_zero;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read port, with bypass of a write to the same entry in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_q        <= r_mem[i_rd.addr];
            r_fwd_hit  <= i_wr.en && (i_wr.addr == i_rd.addr);
            r_fwd_data <= i_wr.data;
            r_zero     <= i_rd.zero;
        end
    end

    // entries not yet written since restart read as zero
    assign o_rd_data = r_zero    ? '0 :
                       r_fwd_hit ? r_fwd_data : r_q;

endmodule

FILE: hw/rtl/lz_byte_decompressor_core.sv
// lz byte decompressor core
// input channel (i_in_valid / o_in_stall / i_in_byte): one compressed byte per
//   transaction; a byte is taken at a clock edge with i_in_valid high and
//   o_in_stall low
// output channel (o_out_valid / i_out_stall / o_out_byte, o_run_last,
//   o_stream_done): one decompressed byte per transaction from an output
//   register; o_run_last marks the last byte caused by an input byte,
//   o_stream_done the byte that completes output_length
// configuration: apb-style port, output_length at byte address 0; writing it
//   restarts the stream (window, counters and parser); write only while idle
// latency: a literal byte shows on the output the cycle after it is taken;
//   after its second token byte, a match reads its first byte into the window
//   read register and moves it on to the output register as the output allows
// throughput: one output byte per cycle while the output does not stall, set
//   by the single read port of the 2048-byte history ram; input waits in a copy
// reset: output_length is zero, so all input is taken and dropped until it
//   is written; the window needs no clearing pass, unwritten entries read zero
// stall: while i_out_stall holds a byte in the output register, literal bytes
//   and the match copy wait; token bytes are still taken
module lz_byte_decompressor_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // compressed input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [lzbd_pkg::BYTE_W-1:0]       i_in_byte,
    // decompressed output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lzbd_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                              o_run_last,
    output logic                              o_stream_done,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lzbd_pkg::PADDR_W-1:0]      paddr,
    input  logic [lzbd_pkg::PDATA_W-1:0]      pwdata,
    output logic [lzbd_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import lzbd_pkg::*;

    // registers
    logic [LEN_W-1:0]  r_out_len,   n_out_len;
    logic [LEN_W-1:0]  r_produced,  n_produced;
    logic [WIN_AW-1:0] r_wp,        n_wp;
    logic              r_wrapped,   n_wrapped;
    t_phase            r_phase,     n_phase;
    logic [RUN_W-1:0]  r_lit_left,  n_lit_left;
    logic [HIGH_W-1:0] r_match_high, n_match_high;
    logic [DIST_W-1:0] r_dm1,       n_dm1;
    logic [COPY_W-1:0] r_issue_left, n_issue_left;
    logic [COPY_W-1:0] r_copy_left, n_copy_left;
    logic              r_pend,      n_pend;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_run_last;
    logic              r_stream_done;

    // control
    logic              cfg_wr;
    logic              done;
    logic [LEN_W-1:0]  remaining;
    logic              out_ready;
    logic              in_ready;
    logic              live;
    logic              emit_lit;
    logic              emit_copy;
    logic              emit;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_last;
    logic              emit_done;
    logic              rd_go;
    logic [WIN_AW-1:0] pos;
    logic [WIN_AW-1:0] dist_ext;
    logic              wrapped_eff;
    logic [RUN_W-1:0]  run_len;
    logic [COPY_W-1:0] match_len;
    logic [BYTE_W-1:0] win_data;
    t_win_rd           win_rd;
    t_win_wr           win_wr;

    // apb register file: a single register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[PADDR_W-1:2] == REG_OUTPUT_LENGTH);
    assign prdata = (paddr[PADDR_W-1:2] == REG_OUTPUT_LENGTH) ? r_out_len : '0;

    assign done      = (r_produced == r_out_len);
    assign remaining = r_out_len - r_produced;
    assign out_ready = !r_out_valid || !i_out_stall;

    // the input waits during a copy, and literals wait for the output slot;
    // once the stream is complete every byte is taken and dropped
    always_comb begin
        unique case (r_phase)
            PH_COPY:    in_ready = 1'b0;
            PH_LITERAL: in_ready = done || out_ready;
            default:    in_ready = 1'b1;
        endcase
    end

    assign o_in_stall = !in_ready;
    assign live       = i_in_valid && in_ready && !done;
    assign emit_lit   = live && (r_phase == PH_LITERAL);
    assign emit_copy  = (r_phase == PH_COPY) && r_pend && out_ready;
    assign emit       = emit_lit || emit_copy;
    assign emit_byte  = emit_lit ? i_in_byte : win_data;
    assign emit_last  = emit_lit || (r_copy_left == COPY_W'(1));
    assign emit_done  = ((r_produced + LEN_W'(1)) == r_out_len);

    // copy read issue: one read in flight, the next issued as the previous
    // byte leaves for the output register
    assign rd_go       = (r_phase == PH_COPY) && (r_issue_left != '0) &&
                         (!r_pend || emit_copy);
    assign pos         = emit_copy ? r_wp + WIN_AW'(1) : r_wp;
    assign dist_ext    = WIN_AW'(r_dm1);
    assign wrapped_eff = r_wrapped || (emit_copy && (r_wp == WIN_AW'(WINDOW_DEPTH - 1)));

    assign win_rd.en   = rd_go;
    assign win_rd.addr = pos - dist_ext - WIN_AW'(1);
    // source lies before the first byte written since restart
    assign win_rd.zero = !wrapped_eff && (pos <= dist_ext);

    assign win_wr.en   = emit;
    assign win_wr.addr = r_wp;
    assign win_wr.data = emit_byte;

    lzbd_window u_window (
        .i_clk     (i_clk),
        .i_wr      (win_wr),
        .i_rd      (win_rd),
        .o_rd_data (win_data)
    );

    // clamped lengths of a literal run and of a match
    always_comb begin
        logic [RUN_W-1:0]  run_raw;
        logic [COPY_W-1:0] len_raw;
        run_raw   = {1'b0, i_in_byte[RUN_W-2:0]} + RUN_W'(1);
        run_len   = (remaining < LEN_W'(run_raw)) ? remaining[RUN_W-1:0] : run_raw;
        len_raw   = {1'b0, r_match_high[HIGH_W-1:3], 1'b0} + COPY_W'(2);
        match_len = (remaining < LEN_W'(len_raw)) ? remaining[COPY_W-1:0] : len_raw;
    end

    always_comb begin
        n_out_len    = r_out_len;
        n_produced   = r_produced;
        n_wp         = r_wp;
        n_wrapped    = r_wrapped;
        n_phase      = r_phase;
        n_lit_left   = r_lit_left;
        n_match_high = r_match_high;
        n_dm1        = r_dm1;
        n_issue_left = r_issue_left;
        n_copy_left  = r_copy_left;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;

        // output register
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // history write pointer and byte count
        if (emit) begin
            n_produced = r_produced + LEN_W'(1);
            n_wp       = r_wp + WIN_AW'(1);
            if (r_wp == WIN_AW'(WINDOW_DEPTH - 1)) begin
                n_wrapped = 1'b1;
            end
        end

        // copy engine
        if (rd_go) begin
            n_pend       = 1'b1;
            n_issue_left = r_issue_left - COPY_W'(1);
        end else if (emit_copy) begin
            n_pend = 1'b0;
        end
        if (emit_copy) begin
            n_copy_left = r_copy_left - COPY_W'(1);
            if (r_copy_left == COPY_W'(1)) begin
                n_phase = PH_TOKEN;
            end
        end

        // parser
        if (live) begin
            unique case (r_phase)
                PH_TOKEN: begin
                    if (i_in_byte[TOKEN_MATCH_BIT]) begin
                        n_match_high = i_in_byte[HIGH_W-1:0];
                        n_phase      = PH_MATCH_LOW;
                    end else begin
                        n_lit_left = run_len;
                        n_phase    = PH_LITERAL;
                    end
                end
                PH_LITERAL: begin
                    n_lit_left = r_lit_left - RUN_W'(1);
                    if (r_lit_left == RUN_W'(1)) begin
                        n_phase = PH_TOKEN;
                    end
                end
                PH_MATCH_LOW: begin
                    n_dm1        = {r_match_high[2:0], i_in_byte};
                    n_issue_left = match_len;
                    n_copy_left  = match_len;
                    n_match_high = '0;
                    n_phase      = PH_COPY;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        // writing output_length restarts the stream
        if (cfg_wr) begin
            n_out_len    = pwdata;
            n_produced   = '0;
            n_wp         = '0;
            n_wrapped    = 1'b0;
            n_phase      = PH_TOKEN;
            n_lit_left   = '0;
            n_match_high = '0;
            n_issue_left = '0;
            n_copy_left  = '0;
            n_pend       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_len    <= '0;
            r_produced   <= '0;
            r_wp         <= '0;
            r_wrapped    <= 1'b0;
            r_phase      <= PH_TOKEN;
            r_lit_left   <= '0;
            r_match_high <= '0;
            r_dm1        <= '0;
            r_issue_left <= '0;
            r_copy_left  <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_len    <= n_out_len;
            r_produced   <= n_produced;
            r_wp         <= n_wp;
            r_wrapped    <= n_wrapped;
            r_phase      <= n_phase;
            r_lit_left   <= n_lit_left;
            r_match_high <= n_match_high;
            r_dm1        <= n_dm1;
            r_issue_left <= n_issue_left;
            r_copy_left  <= n_copy_left;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte    <= emit_byte;
            r_run_last    <= emit_last;
            r_stream_done <= emit_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_run_last    = r_run_last;
    assign o_stream_done = r_stream_done;

endmodule
